>>> rtl/lcsu_pkg.sv
// lcsu_pkg: shared constants and types for the lru cache set update unit
// no dependencies; used by lcsu_cell and lru_cache_set_update_unit

package lcsu_pkg;

    localparam int MAX_WAYS     = 8;
    localparam int TAG_BITS     = 32;
    localparam int CFG_BITS     = 4;
    localparam int WAY_IDX_BITS = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    localparam logic [CFG_BITS-1:0] WAYS_RESET = CFG_BITS'(MAX_WAYS);

    // per-access control broadcast to every cell of the recency stack
    typedef struct packed {
        logic accept;   // an item is taken this cycle
        logic hit;      // the tag matched some held way
        logic full;     // miss replaces the tail instead of growing the set
    } lcsu_ctl_t;

endpackage

>>> rtl/lcsu_cell.sv
// lcsu_cell: one position of the recency stack (tag plus valid bit)
// compares against the access tag and loads from its more-recent neighbor
// depends on lcsu_pkg

module lcsu_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lcsu_pkg::lcsu_ctl_t          ctl,
    input  logic [lcsu_pkg::TAG_BITS-1:0] lookup_tag,
    input  logic                         prev_valid,
    input  logic [lcsu_pkg::TAG_BITS-1:0] prev_tag,
    input  logic                         seen_in,
    output logic                         valid,
    output logic [lcsu_pkg::TAG_BITS-1:0] tag,
    output logic                         seen_out
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [lcsu_pkg::TAG_BITS-1:0] tag_reg;
    logic [lcsu_pkg::TAG_BITS-1:0] tag_next;
    logic                          match;
    logic                          shift;

    assign match    = valid_reg && (tag_reg == lookup_tag);
    assign seen_out = seen_in | match;

    // hit: positions up to and including the matching one move back
    // full miss: every held position moves, the tail drops off
    // insert: positions up to one past the tail move
    always_comb begin
        if (ctl.hit) begin
            shift = !seen_in;
        end else if (ctl.full) begin
            shift = valid_reg;
        end else begin
            shift = prev_valid;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        if (ctl.accept && shift) begin
            valid_next = prev_valid;
            tag_next   = prev_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;

endmodule

>>> rtl/lru_cache_set_update_unit.sv
// lru_cache_set_update_unit: one cache set with true lru replacement
// depends on lcsu_pkg and lcsu_cell

// One set of a set-associative cache kept as a recency stack of MAX_WAYS
// cells, most recent first. Each input item is one access tag. It is compared
// against all held ways in the same cycle, and the stack shifts by one cell on
// the same edge, so the block takes one item per clock. The result (hit,
// evicted, evicted_tag) is loaded into the output register on the edge that
// takes the item. A new item is taken only when that register is empty or its
// result is taken in the same cycle, so a held result stalls the input. The limit on
// speed is the combinational compare-and-shift across the cell chain. The set is
// empty after reset. cfg_ways_in_use (reset 8, 0 acts as 1, values above
// MAX_WAYS act as MAX_WAYS) sets how many ways fill before the tail is evicted.

module lru_cache_set_update_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lcsu_pkg::CFG_BITS-1:0] cfg_ways_in_use,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lcsu_pkg::TAG_BITS-1:0] s_access_tag,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic                          m_evicted,
    output logic [lcsu_pkg::TAG_BITS-1:0] m_evicted_tag
);

    localparam int NW = lcsu_pkg::MAX_WAYS;
    localparam int TB = lcsu_pkg::TAG_BITS;
    localparam int CB = lcsu_pkg::CFG_BITS;
    localparam int IB = lcsu_pkg::WAY_IDX_BITS;

    logic [CB-1:0]         ways_reg;
    logic [CB-1:0]         ways_next;
    logic [IB-1:0]         tail_idx;
    logic                  full;
    logic                  hit;
    logic                  evict;
    logic [TB-1:0]         evict_tag;
    lcsu_pkg::lcsu_ctl_t   ctl;

    logic [NW-1:0]         cell_valid;
    logic [TB-1:0]         cell_tag [NW];
    logic [NW:0]           valid_ext;
    logic [NW:0]           seen;
    logic                  prev_valid [NW];
    logic [TB-1:0]         prev_tag [NW];

    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic                  m_hit_reg;
    logic                  m_hit_next;
    logic                  m_evicted_reg;
    logic                  m_evicted_next;
    logic [TB-1:0]         m_evicted_tag_reg;
    logic [TB-1:0]         m_evicted_tag_next;

    // configuration
    assign cfg_ready = 1'b1;
    assign ways_next = (cfg_valid) ? cfg_ways_in_use : ways_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ways_reg <= lcsu_pkg::WAYS_RESET;
        end else begin
            ways_reg <= ways_next;
        end
    end

    // clamp associativity into [1, MAX_WAYS] as a position of the last way
    always_comb begin
        if (ways_reg == '0) begin
            tail_idx = '0;
        end else if (ways_reg > CB'(NW)) begin
            tail_idx = IB'(NW - 1);
        end else begin
            tail_idx = IB'(ways_reg - 1'b1);
        end
    end

    // valid bits form a prefix, so the set is full when the last allowed way is held
    assign full = cell_valid[tail_idx];

    assign s_ready = !m_valid_reg || m_ready;

    assign hit   = seen[NW];
    assign evict = !hit && full;

    assign ctl.accept = s_valid && s_ready;
    assign ctl.hit    = hit;
    assign ctl.full   = full;

    assign seen[0]   = 1'b0;
    assign valid_ext = {1'b0, cell_valid};

    genvar g;
    generate
        for (g = 0; g < NW; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign prev_valid[g] = 1'b1;
                assign prev_tag[g]   = s_access_tag;
            end else begin : g_body
                assign prev_valid[g] = cell_valid[g-1];
                assign prev_tag[g]   = cell_tag[g-1];
            end

            lcsu_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .lookup_tag (s_access_tag),
                .prev_valid (prev_valid[g]),
                .prev_tag   (prev_tag[g]),
                .seen_in    (seen[g]),
                .valid      (cell_valid[g]),
                .tag        (cell_tag[g]),
                .seen_out   (seen[g+1])
            );
        end
    endgenerate

    // tail of the held prefix is the one being dropped
    always_comb begin
        evict_tag = '0;
        for (int i = 0; i < NW; i++) begin
            if (valid_ext[i] && !valid_ext[i+1]) begin
                evict_tag = evict_tag | cell_tag[i];
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next       = m_valid_reg;
        m_hit_next         = m_hit_reg;
        m_evicted_next     = m_evicted_reg;
        m_evicted_tag_next = m_evicted_tag_reg;
        if (ctl.accept) begin
            m_valid_next       = 1'b1;
            m_hit_next         = hit;
            m_evicted_next     = evict;
            m_evicted_tag_next = evict ? evict_tag : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_hit_reg         <= m_hit_next;
        m_evicted_reg     <= m_evicted_next;
        m_evicted_tag_reg <= m_evicted_tag_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_evicted     = m_evicted_reg;
    assign m_evicted_tag = m_evicted_tag_reg;

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for the lru cache set update unit
// drives random access tags and ways settings, predicts hit and eviction per item
// depends on lcsu_pkg and lru_cache_set_update_unit
`timescale 1ns / 100ps

module tb_top;

    localparam int CHOKE_CYCLES = 400;
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS = 107;

    typedef struct packed {
        logic                          hit;
        logic                          evicted;
        logic [lcsu_pkg::TAG_BITS-1:0] evicted_tag;
    } access_outcome_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [lcsu_pkg::CFG_BITS-1:0] cfg_ways_in_use = '0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [lcsu_pkg::TAG_BITS-1:0] s_access_tag = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_hit;
    logic                          m_evicted;
    logic [lcsu_pkg::TAG_BITS-1:0] m_evicted_tag;

    // model of the set: tags most recent first, held count and ways register
    logic [lcsu_pkg::TAG_BITS-1:0] recency [lcsu_pkg::MAX_WAYS];
    int                            lines_held = 0;
    logic [lcsu_pkg::CFG_BITS-1:0] ways_cfg = lcsu_pkg::WAYS_RESET;

    logic [lcsu_pkg::TAG_BITS-1:0] tags_to_send [$];
    access_outcome_t               outcomes_due [$];

    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;
    int choke_reqs = 0;
    int choke_seen = 0;
    int choke_left = 0;
    int src_gap = 0;
    int sink_wait = 0;
    int errors = 0;
    int results_seen = 0;
    int hits_seen = 0;
    int evictions_seen = 0;
    int settings_used = 0;

    lru_cache_set_update_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_ways_in_use (cfg_ways_in_use),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_access_tag    (s_access_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_evicted       (m_evicted),
        .m_evicted_tag   (m_evicted_tag)
    );

    always #2 aclk = ~aclk;

    function automatic int draw_wait(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 13));
    endfunction

    // look the tag up, move it to the front and report what fell out
    function automatic access_outcome_t set_access(
        input logic [lcsu_pkg::TAG_BITS-1:0] tag
    );
        access_outcome_t res;
        int limit;
        int slot;
        int upto;
        res = '0;
        if (ways_cfg == 0) limit = 1;
        else if (ways_cfg > lcsu_pkg::MAX_WAYS) limit = lcsu_pkg::MAX_WAYS;
        else limit = int'(ways_cfg);
        slot = -1;
        for (int i = 0; i < lines_held; i++)
            if (slot < 0 && recency[i] == tag) slot = i;
        if (slot >= 0) begin
            res.hit = 1'b1;
            upto = slot;
        end else if (lines_held >= limit && lines_held > 0) begin
            // set counts as full, even when the limit dropped below the held count
            res.evicted = 1'b1;
            res.evicted_tag = recency[lines_held-1];
            upto = lines_held - 1;
        end else begin
            upto = lines_held;
            if (lines_held < lcsu_pkg::MAX_WAYS) lines_held++;
        end
        if (upto > lcsu_pkg::MAX_WAYS - 1) upto = lcsu_pkg::MAX_WAYS - 1;
        for (int i = upto; i > 0; i--) recency[i] = recency[i-1];
        recency[0] = tag;
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else if (s_valid && !s_ready) begin
            // item still waiting
        end else begin
            if (s_valid) outcomes_due.push_back(set_access(s_access_tag));
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                s_valid <= 1'b0;
            end else if (tags_to_send.size() != 0) begin
                s_access_tag <= tags_to_send.pop_front();
                s_valid <= 1'b1;
                src_gap <= draw_wait(src_steady);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : result_monitor
        access_outcome_t want;
        int w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait <= 0;
            choke_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0) begin
                    $display("%0t: result with nothing expected: hit %0b evicted %0b tag %h",
                             $time, m_hit, m_evicted, m_evicted_tag);
                    errors++;
                end else begin
                    want = outcomes_due.pop_front();
                    results_seen++;
                    hits_seen += int'(want.hit);
                    evictions_seen += int'(want.evicted);
                    if (m_hit !== want.hit) begin
                        $display("%0t: hit expected %0b, got %0b", $time, want.hit, m_hit);
                        errors++;
                    end
                    if (m_evicted !== want.evicted) begin
                        $display("%0t: evicted expected %0b, got %0b",
                                 $time, want.evicted, m_evicted);
                        errors++;
                    end
                    if (m_evicted_tag !== want.evicted_tag) begin
                        $display("%0t: evicted_tag expected %h, got %h",
                                 $time, want.evicted_tag, m_evicted_tag);
                        errors++;
                    end
                end
            end
            if (choke_seen != choke_reqs) begin
                // long hold-off so the block backs up into its input
                choke_seen <= choke_reqs;
                choke_left <= CHOKE_CYCLES;
                m_ready <= 1'b0;
            end else if (choke_left > 1) begin
                choke_left <= choke_left - 1;
            end else if (choke_left == 1) begin
                choke_left <= 0;
                m_ready <= 1'b1;
            end else if (m_valid && m_ready) begin
                w = draw_wait(sink_steady);
                sink_wait <= (w > 0) ? w - 1 : 0;
                m_ready <= (w == 0);
            end else if (!m_ready) begin
                if (sink_wait > 0) sink_wait <= sink_wait - 1;
                else m_ready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        while (tags_to_send.size() != 0 || s_valid || outcomes_due.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_ways(input logic [lcsu_pkg::CFG_BITS-1:0] w);
        @(posedge aclk);
        cfg_ways_in_use <= w;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        ways_cfg = w;
        settings_used++;
    endtask

    initial begin : stimulus
        logic [lcsu_pkg::TAG_BITS-1:0] pool [$];
        int pool_size;
        int pick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset ways value; tag zero on an empty set must miss
        tags_to_send.push_back(32'h0000_0000);
        tags_to_send.push_back(32'hFFFF_FFFF);
        tags_to_send.push_back(32'h0000_0000);
        tags_to_send.push_back(32'hAAAA_AAAA);
        wait_idle();

        // zero acts as one way; three held, so misses evict the tail
        write_ways(4'd0);
        tags_to_send.push_back(32'h0000_0005);
        tags_to_send.push_back(32'h0000_0000);
        tags_to_send.push_back(32'h5555_5555);
        wait_idle();

        write_ways(4'd4);
        tags_to_send.push_back(32'h0000_0001);
        tags_to_send.push_back(32'h0000_0002);
        tags_to_send.push_back(32'h0000_0002);
        wait_idle();

        // above the way count acts as the full set: grow to eight then evict
        write_ways(4'd12);
        tags_to_send.push_back(32'h0000_0003);
        tags_to_send.push_back(32'h0000_0004);
        tags_to_send.push_back(32'h8000_0000);
        tags_to_send.push_back(32'h7FFF_FFFF);
        tags_to_send.push_back(32'h0000_0006);
        tags_to_send.push_back(32'h0000_0002);
        tags_to_send.push_back(32'hFFFF_FFFF);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            if (p == 0) write_ways(4'd15);
            else if (p == 1) write_ways(4'd1);
            else if (p == 2) write_ways(4'd8);
            else if (p == 3) write_ways(4'd0);
            else write_ways(4'($urandom_range(0, 15)));
            src_steady = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            if (p == 5) begin
                src_steady = 1'b1;
                choke_reqs++;
            end
            // small tag pool per phase so hits and evictions both occur often
            pool.delete();
            pool_size = $urandom_range(2, 12);
            for (int k = 0; k < pool_size; k++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) pool.push_back(32'h0000_0000);
                else if (pick == 1) pool.push_back(32'hFFFF_FFFF);
                else pool.push_back($urandom);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 85)
                    tags_to_send.push_back(pool[$urandom_range(0, pool.size() - 1)]);
                else
                    tags_to_send.push_back($urandom);
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        $display("covered %0d accesses with %0d hits and %0d evictions",
                 results_seen, hits_seen, evictions_seen);
        $display("over %0d ways settings, including a long output stall", settings_used);
        if (outcomes_due.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, outcomes_due.size());
        if (errors == 0 && outcomes_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("timeout with %0d results outstanding", outcomes_due.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
